// ----- sv/ctid_pkg.sv -----
`timescale 1ns / 1ps
// Package for the complete binary tree store: default capacity, operation and
// status codes, controller states and the command/status structs between the
// controller and the datapath. No dependencies.
package ctid_pkg;

  localparam int unsigned CAPACITY = 64;

  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_DELETE   = 2'd1,
    KIND_TRAVERSE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4,
    ST_ELEMENT   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DEL_LAST,
    S_DEL_SCAN,
    S_TR_DOWN,
    S_TR_FETCH,
    S_TR_EMIT,
    S_TR_UP
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_ONE,
    PTR_LEFT,
    PTR_RIGHT,
    PTR_UP
  } ptr_op_e;

  typedef enum logic [1:0] {
    RD_LAST,
    RD_PTR,
    RD_NODE
  } rd_sel_e;

  typedef struct packed {
    logic    latch_in;
    logic    ins_write;
    logic    del_write;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    rd_en;
    rd_sel_e rd_sel;
    ptr_op_e ptr_op;
    logic    scan_clr;
    logic    scan_step;
    logic    latch_last;
    logic    emit;
    status_e emit_status;
    logic    emit_elem;
    logic    emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       cnt_zero;
    logic       cnt_full;
    logic       left_ok;
    logic       right_ok;
    logic       node_last;
    logic       node_odd;
    logic       match;
    logic       scan_done;
    logic       out_free;
  } dp_status_t;

endpackage

// ----- sv/complete_tree_insert_delete.sv -----
`timescale 1ns / 1ps
// Top level of the complete binary tree store (insert, delete, inorder dump).
// Instantiates ctid_ctrl and ctid_dp; uses ctid_pkg.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------
//   in      | input     | in_valid_i / in_stall_o | kind_i, value_i
//   out     | output    | out_valid_o / out_stall_i | status_o, item_value_o, last_of_run_o
//
// Insert issues its result from the decode state. Delete reads the last
// entry, then compares one stored entry per cycle through the single
// registered read port. Traversal emits values in order, walking the pointer
// down or up one tree level at a time between values. One at a time.
// Reset clears the entry count and control state only; the store is not swept.
// A stalled result holds in the output register and the engine waits on it.
module complete_tree_insert_delete #(
  parameter int unsigned CAPACITY = ctid_pkg::CAPACITY
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] item_value_o,
  output logic               last_of_run_o
);

  ctid_pkg::dp_cmd_t    dp_cmd;
  ctid_pkg::dp_status_t dp_status;

  ctid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  ctid_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (kind_i),
    .value_i       (value_i),
    .cmd_i         (dp_cmd),
    .status_o      (dp_status),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_status_o  (status_o),
    .item_value_o  (item_value_o),
    .last_of_run_o (last_of_run_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted twice in a row");

  a_emit_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.emit |-> (!out_valid_o || !out_stall_i))
    else $error("result issued over a stalled result");

  a_status_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ctid_pkg::ST_ELEMENT) |-> last_of_run_o)
    else $error("status result not marked last");

  a_status_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ctid_pkg::ST_ELEMENT) |-> (item_value_o == 32'sd0))
    else $error("status result carries a value");
`endif

endmodule

// ----- sv/ctid_dp.sv -----
`timescale 1ns / 1ps
// Datapath: value store, entry count, walk pointer, scan compare and the
// output register. Driven by ctid_ctrl commands; uses ctid_pkg types.
module ctid_dp #(
  parameter int unsigned CAPACITY = ctid_pkg::CAPACITY
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           kind_i,
  input  logic signed [31:0]   value_i,
  input  ctid_pkg::dp_cmd_t    cmd_i,
  output ctid_pkg::dp_status_t status_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [2:0]           out_status_o,
  output logic signed [31:0]   item_value_o,
  output logic                 last_of_run_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned NW = $clog2(CAPACITY + 1);

  logic signed [31:0] mem_q [CAPACITY];
  logic signed [31:0] rdata_q;
  logic signed [31:0] val_q;
  logic signed [31:0] last_val_q;
  logic [1:0]         kind_q;
  logic [NW-1:0]      cnt_q, cnt_d;
  logic [NW-1:0]      ptr_q, ptr_d;
  logic [IW-1:0]      rd_idx_q;
  logic               rd_v_q, rd_v_d;
  logic               out_valid_q, out_valid_d;
  logic [2:0]         out_status_q;
  logic signed [31:0] out_item_q;
  logic               out_last_q;

  logic [NW:0]   ptr_ext, left, right, cnt_ext;
  logic [NW-1:0] ptr_m1, cnt_m1;
  logic          ptr_lt_cnt;
  logic          rd_fire;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic signed [31:0] wr_data;

  assign ptr_ext    = {1'b0, ptr_q};
  assign cnt_ext    = {1'b0, cnt_q};
  assign left       = {ptr_q, 1'b0};
  assign right      = {ptr_q, 1'b1};
  assign ptr_m1     = ptr_q - 1'b1;
  assign cnt_m1     = cnt_q - 1'b1;
  assign ptr_lt_cnt = (ptr_q < cnt_q);

  assign status_o.kind      = kind_q;
  assign status_o.cnt_zero  = (cnt_q == '0);
  assign status_o.cnt_full  = (cnt_q == NW'(CAPACITY));
  assign status_o.left_ok   = (left <= cnt_ext);
  assign status_o.right_ok  = (right <= cnt_ext);
  assign status_o.node_last = ((ptr_ext & (ptr_ext + 1'b1)) == '0) && (right > cnt_ext);
  assign status_o.node_odd  = ptr_q[0];
  assign status_o.match     = rd_v_q && (rdata_q == val_q);
  assign status_o.scan_done = !rd_v_q && !ptr_lt_cnt;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign rd_fire = cmd_i.rd_en || (cmd_i.scan_step && ptr_lt_cnt);

  always_comb begin
    rd_addr = ptr_q[IW-1:0];
    if (!cmd_i.scan_step) begin
      case (cmd_i.rd_sel)
        ctid_pkg::RD_LAST: rd_addr = cnt_m1[IW-1:0];
        ctid_pkg::RD_PTR:  rd_addr = ptr_q[IW-1:0];
        ctid_pkg::RD_NODE: rd_addr = ptr_m1[IW-1:0];
        default:           rd_addr = ptr_q[IW-1:0];
      endcase
    end
  end

  always_comb begin
    wr_en   = cmd_i.ins_write || cmd_i.del_write;
    wr_addr = cmd_i.del_write ? rd_idx_q : cnt_q[IW-1:0];
    wr_data = cmd_i.del_write ? last_val_q : val_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_fire) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    case (cmd_i.ptr_op)
      ctid_pkg::PTR_HOLD: begin
        if (cmd_i.scan_step && ptr_lt_cnt) begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ctid_pkg::PTR_ZERO:  ptr_d = '0;
      ctid_pkg::PTR_ONE:   ptr_d = NW'(1);
      ctid_pkg::PTR_LEFT:  ptr_d = left[NW-1:0];
      ctid_pkg::PTR_RIGHT: ptr_d = right[NW-1:0];
      ctid_pkg::PTR_UP:    ptr_d = ptr_q >> 1;
      default:             ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_m1;
    end
  end

  always_comb begin
    rd_v_d = rd_v_q;
    if (cmd_i.scan_clr) begin
      rd_v_d = 1'b0;
    end else if (cmd_i.scan_step) begin
      rd_v_d = ptr_lt_cnt;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      rd_v_q      <= rd_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.latch_in) begin
      kind_q <= kind_i;
      val_q  <= value_i;
    end
    if (cmd_i.latch_last) begin
      last_val_q <= rdata_q;
    end
    if (cmd_i.scan_step) begin
      rd_idx_q <= ptr_q[IW-1:0];
    end
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.emit_status;
      out_item_q   <= cmd_i.emit_elem ? rdata_q : 32'sd0;
      out_last_q   <= cmd_i.emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign item_value_o  = out_item_q;
  assign last_of_run_o = out_last_q;

endmodule

// ----- sv/ctid_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences insert, delete scan and inorder walk by issuing
// commands to ctid_dp. Uses ctid_pkg states and command/status structs.
module ctid_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ctid_pkg::dp_status_t status_i,
  output ctid_pkg::dp_cmd_t    cmd_o
);

  ctid_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctid_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ctid_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = ctid_pkg::S_DECODE;
        end
      end
      ctid_pkg::S_DECODE: begin
        case (status_i.kind)
          ctid_pkg::KIND_INSERT: begin
            if (status_i.out_free) begin
              state_d = ctid_pkg::S_IDLE;
            end
          end
          ctid_pkg::KIND_DELETE: begin
            if (!status_i.cnt_zero) begin
              state_d = ctid_pkg::S_DEL_LAST;
            end else if (status_i.out_free) begin
              state_d = ctid_pkg::S_IDLE;
            end
          end
          ctid_pkg::KIND_TRAVERSE: begin
            if (!status_i.cnt_zero) begin
              state_d = ctid_pkg::S_TR_DOWN;
            end else if (status_i.out_free) begin
              state_d = ctid_pkg::S_IDLE;
            end
          end
          default: state_d = ctid_pkg::S_IDLE;
        endcase
      end
      ctid_pkg::S_DEL_LAST: state_d = ctid_pkg::S_DEL_SCAN;
      ctid_pkg::S_DEL_SCAN: begin
        if ((status_i.match || status_i.scan_done) && status_i.out_free) begin
          state_d = ctid_pkg::S_IDLE;
        end
      end
      ctid_pkg::S_TR_DOWN: begin
        if (!status_i.left_ok) begin
          state_d = ctid_pkg::S_TR_EMIT;
        end
      end
      ctid_pkg::S_TR_FETCH: state_d = ctid_pkg::S_TR_EMIT;
      ctid_pkg::S_TR_EMIT: begin
        if (status_i.out_free) begin
          if (status_i.node_last) begin
            state_d = ctid_pkg::S_IDLE;
          end else if (status_i.right_ok) begin
            state_d = ctid_pkg::S_TR_DOWN;
          end else begin
            state_d = ctid_pkg::S_TR_UP;
          end
        end
      end
      ctid_pkg::S_TR_UP: begin
        if (!status_i.node_odd) begin
          state_d = ctid_pkg::S_TR_FETCH;
        end
      end
      default: state_d = ctid_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = ctid_pkg::RD_PTR;
    cmd_o.ptr_op = ctid_pkg::PTR_HOLD;
    in_stall_o   = 1'b1;
    case (state_q)
      ctid_pkg::S_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.latch_in = in_valid_i;
      end
      ctid_pkg::S_DECODE: begin
        case (status_i.kind)
          ctid_pkg::KIND_INSERT: begin
            if (status_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              if (status_i.cnt_full) begin
                cmd_o.emit_status = ctid_pkg::ST_FULL;
              end else begin
                cmd_o.ins_write   = 1'b1;
                cmd_o.cnt_inc     = 1'b1;
                cmd_o.emit_status = ctid_pkg::ST_INSERTED;
              end
            end
          end
          ctid_pkg::KIND_DELETE: begin
            if (!status_i.cnt_zero) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = ctid_pkg::RD_LAST;
            end else if (status_i.out_free) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_last   = 1'b1;
              cmd_o.emit_status = ctid_pkg::ST_EMPTY;
            end
          end
          ctid_pkg::KIND_TRAVERSE: begin
            if (!status_i.cnt_zero) begin
              cmd_o.ptr_op = ctid_pkg::PTR_ONE;
            end else if (status_i.out_free) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_last   = 1'b1;
              cmd_o.emit_status = ctid_pkg::ST_EMPTY;
            end
          end
          default: ;
        endcase
      end
      ctid_pkg::S_DEL_LAST: begin
        cmd_o.latch_last = 1'b1;
        cmd_o.scan_clr   = 1'b1;
        cmd_o.ptr_op     = ctid_pkg::PTR_ZERO;
      end
      ctid_pkg::S_DEL_SCAN: begin
        if (status_i.match) begin
          if (status_i.out_free) begin
            cmd_o.del_write   = 1'b1;
            cmd_o.cnt_dec     = 1'b1;
            cmd_o.emit        = 1'b1;
            cmd_o.emit_last   = 1'b1;
            cmd_o.emit_status = ctid_pkg::ST_DELETED;
          end
        end else if (status_i.scan_done) begin
          if (status_i.out_free) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_last   = 1'b1;
            cmd_o.emit_status = ctid_pkg::ST_NOT_FOUND;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ctid_pkg::S_TR_DOWN: begin
        if (status_i.left_ok) begin
          cmd_o.ptr_op = ctid_pkg::PTR_LEFT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ctid_pkg::RD_NODE;
        end
      end
      ctid_pkg::S_TR_FETCH: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ctid_pkg::RD_NODE;
      end
      ctid_pkg::S_TR_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_elem   = 1'b1;
          cmd_o.emit_last   = status_i.node_last;
          cmd_o.emit_status = ctid_pkg::ST_ELEMENT;
          if (!status_i.node_last && status_i.right_ok) begin
            cmd_o.ptr_op = ctid_pkg::PTR_RIGHT;
          end
        end
      end
      ctid_pkg::S_TR_UP: begin
        cmd_o.ptr_op = ctid_pkg::PTR_UP;
      end
      default: ;
    endcase
  end

endmodule
